// ----- hw/rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an active-low reset disable.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check that a condition never holds at a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ----- hw/rtl/mm_pkg.sv -----
// -----------------------------------------------------------------------------
// Matrix multiply package
// Item types, command and register codes, and dimension helper.
// -----------------------------------------------------------------------------
package mm_pkg;

	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IDX_FW    = 3;
	localparam int ELEM_W    = 16;
	localparam int ACC_W     = 40;
	localparam int CMD_W     = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_FW-1:0]        elem_row;
		logic [IDX_FW-1:0]        elem_col;
		logic signed [ELEM_W-1:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_FW-1:0]       out_row;
		logic [IDX_FW-1:0]       out_col;
		logic signed [ACC_W-1:0] out_value;
		logic                    last;
	} out_item_t;

	typedef struct packed {
		logic b_we;
		logic capture;
		logic shift;
	} cell_ctl_t;

	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] lim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/mm_cell.sv -----
// -----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of B, multiplies the passing A element and accumulates.
// -----------------------------------------------------------------------------
module mm_cell #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 16,
	parameter int IDX_W       = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mm_pkg::cell_ctl_t                ctl,
	input  logic [IDX_W-1:0]                 b_waddr,
	input  logic signed [VALUE_WIDTH-1:0]    b_wdata,
	input  logic signed [VALUE_WIDTH-1:0]    a_in,
	input  logic [IDX_W-1:0]                 t_in,
	input  logic                             vld_in,
	input  logic                             first_in,
	input  logic                             last_in,
	output logic signed [VALUE_WIDTH-1:0]    a_out,
	output logic [IDX_W-1:0]                 t_out,
	output logic                             vld_out,
	output logic                             first_out,
	output logic                             last_out,
	input  logic signed [mm_pkg::ACC_W-1:0]  res_in,
	output logic signed [mm_pkg::ACC_W-1:0]  res_out
);

	localparam int PW = 2 * VALUE_WIDTH;
	localparam int AW = mm_pkg::ACC_W;

	logic signed [VALUE_WIDTH-1:0] b_q [MAX_DIM];
	logic signed [VALUE_WIDTH-1:0] a_q;
	logic [IDX_W-1:0]              t_q;
	logic                          vld_q;
	logic                          first_q;
	logic                          last_q;
	logic signed [PW-1:0]          prod_s1;
	logic                          pvld_s1;
	logic                          pfirst_s1;
	logic signed [AW-1:0]          prod_ext;
	logic signed [AW-1:0]          acc_q;
	logic signed [AW-1:0]          res_q;

	assign prod_ext = AW'(prod_s1);

	always_ff @(posedge clk) begin
		if (ctl.b_we) begin
			b_q[b_waddr] <= b_wdata;
		end
		a_q     <= a_in;
		t_q     <= t_in;
		prod_s1 <= a_in * b_q[t_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			first_q   <= 1'b0;
			last_q    <= 1'b0;
			pvld_s1   <= 1'b0;
			pfirst_s1 <= 1'b0;
			acc_q     <= '0;
			res_q     <= '0;
		end else begin
			vld_q     <= vld_in;
			first_q   <= first_in;
			last_q    <= last_in;
			pvld_s1   <= vld_in;
			pfirst_s1 <= first_in;
			if (pvld_s1) begin
				acc_q <= pfirst_s1 ? prod_ext : AW'(acc_q + prod_ext);
			end
			if (ctl.capture) begin
				res_q <= acc_q;
			end else if (ctl.shift) begin
				res_q <= res_in;
			end
		end
	end

	assign a_out     = a_q;
	assign t_out     = t_q;
	assign vld_out   = vld_q;
	assign first_out = first_q;
	assign last_out  = last_q;
	assign res_out   = res_q;

endmodule

// ----- hw/rtl/matrix_multiply.sv -----
// -----------------------------------------------------------------------------
// Matrix multiply
// Computes C = A * B over signed fixed-point elements with a chain of cells.
//
// Items arrive on item_valid / item / item_stall; a transfer happens when
// item_valid is high and item_stall low. Loads of A or B do not stall the input,
// and the block can take the next item in the following cycle.
// A compute item stalls the input until every element of C has been sent on
// result_valid / result / result_stall, row by row, the final one with last.
// Each row of C streams inner_dim elements of A through the cell chain, waits
// for the chain to settle, then makes cols_b result transfers; a stalled
// receiver simply holds the current result.
// Configuration writes on cfg_valid / cfg_ready are always taken.
// Reset sets all three dimensions to eight and returns to idle; matrix
// contents stay undefined until loaded.
// -----------------------------------------------------------------------------
module matrix_multiply #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  mm_pkg::in_item_t                 item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output mm_pkg::out_item_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]         cfg_data
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int CW     = mm_pkg::CFG_W;
	localparam int AW     = mm_pkg::ACC_W;
	localparam int FW     = mm_pkg::IDX_FW;
	localparam int EW     = mm_pkg::ELEM_W;
	localparam logic [CW-1:0] DIM_LIM = CW'(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_WAIT,
		ST_DRAIN
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 rows_a_q;
	logic [CW-1:0]                 inner_dim_q;
	logic [CW-1:0]                 cols_b_q;
	logic [CW-1:0]                 dim_m;
	logic [CW-1:0]                 dim_k;
	logic [CW-1:0]                 dim_n;
	logic [IDX_W-1:0]              i_q;
	logic [IDX_W-1:0]              j_q;
	logic [IDX_W-1:0]              t_q;
	logic                          accept;
	logic [IDX_W-1:0]              r_idx;
	logic [IDX_W-1:0]              c_idx;
	logic signed [VALUE_WIDTH-1:0] elem_v;
	logic                          a_we;
	logic                          b_we_any;
	logic [ADDR_W-1:0]             a_waddr;
	logic [ADDR_W-1:0]             a_raddr;
	logic signed [VALUE_WIDTH-1:0] a_mem [MAX_DIM * MAX_DIM];
	logic signed [VALUE_WIDTH-1:0] a_rdata_s1;
	logic [IDX_W-1:0]              tok_t_s1;
	logic                          tok_vld_s1;
	logic                          tok_first_s1;
	logic                          tok_last_s1;
	logic                          done_q;
	logic                          capture;
	logic                          shift;
	logic                          i_last;
	logic                          j_last;

	logic signed [VALUE_WIDTH-1:0] ch_a     [MAX_DIM+1];
	logic [IDX_W-1:0]              ch_t     [MAX_DIM+1];
	logic                          ch_vld   [MAX_DIM+1];
	logic                          ch_first [MAX_DIM+1];
	logic                          ch_last  [MAX_DIM+1];
	logic signed [AW-1:0]          ch_res   [MAX_DIM+1];

	assign dim_m = mm_pkg::eff_dim(rows_a_q, DIM_LIM);
	assign dim_k = mm_pkg::eff_dim(inner_dim_q, DIM_LIM);
	assign dim_n = mm_pkg::eff_dim(cols_b_q, DIM_LIM);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mm_pkg::DIM_RESET;
			inner_dim_q <= mm_pkg::DIM_RESET;
			cols_b_q    <= mm_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data;
				mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mm_pkg::REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign r_idx      = item.elem_row[IDX_W-1:0];
	assign c_idx      = item.elem_col[IDX_W-1:0];

	generate
		if (VALUE_WIDTH <= EW) begin : g_val_narrow
			assign elem_v = item.elem_value[VALUE_WIDTH-1:0];
		end else begin : g_val_wide
			assign elem_v = {{(VALUE_WIDTH-EW){1'b0}}, item.elem_value};
		end
	endgenerate

	assign a_we = accept && (item.cmd == mm_pkg::CMD_LOAD_A)
		&& (CW'(item.elem_row) < dim_m) && (CW'(item.elem_col) < dim_k);
	assign b_we_any = accept && (item.cmd == mm_pkg::CMD_LOAD_B)
		&& (CW'(item.elem_row) < dim_k) && (CW'(item.elem_col) < dim_n);

	assign a_waddr = ADDR_W'(r_idx * MAX_DIM + c_idx);
	assign a_raddr = ADDR_W'(i_q * MAX_DIM + t_q);

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_waddr] <= elem_v;
		end
		a_rdata_s1 <= a_mem[a_raddr];
		tok_t_s1   <= t_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_s1   <= 1'b0;
			tok_first_s1 <= 1'b0;
			tok_last_s1  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			tok_vld_s1   <= (state_q == ST_FEED);
			tok_first_s1 <= (t_q == '0);
			tok_last_s1  <= (CW'(t_q) == CW'(dim_k - 1'b1));
			done_q       <= ch_vld[MAX_DIM] && ch_last[MAX_DIM];
		end
	end

	assign i_last  = (CW'(i_q) == CW'(dim_m - 1'b1));
	assign j_last  = (CW'(j_q) == CW'(dim_n - 1'b1));
	assign capture = (state_q == ST_WAIT) && done_q;
	assign shift   = (state_q == ST_DRAIN) && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			t_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.cmd == mm_pkg::CMD_COMPUTE)) begin
						state_q <= ST_FEED;
						i_q     <= '0;
						t_q     <= '0;
					end
				end
				ST_FEED: begin
					if (CW'(t_q) == CW'(dim_k - 1'b1)) begin
						t_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						t_q <= IDX_W'(t_q + 1'b1);
					end
				end
				ST_WAIT: begin
					if (done_q) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!result_stall) begin
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= IDX_W'(i_q + 1'b1);
								state_q <= ST_FEED;
							end
						end else begin
							j_q <= IDX_W'(j_q + 1'b1);
						end
					end
				end
			endcase
		end
	end

	assign ch_a[0]          = a_rdata_s1;
	assign ch_t[0]          = tok_t_s1;
	assign ch_vld[0]        = tok_vld_s1;
	assign ch_first[0]      = tok_first_s1;
	assign ch_last[0]       = tok_last_s1;
	assign ch_res[MAX_DIM]  = '0;

	generate
		for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
			mm_pkg::cell_ctl_t ctl;

			assign ctl.b_we    = b_we_any && (c_idx == IDX_W'(j));
			assign ctl.capture = capture;
			assign ctl.shift   = shift;

			mm_cell #(
				.MAX_DIM     (MAX_DIM),
				.VALUE_WIDTH (VALUE_WIDTH),
				.IDX_W       (IDX_W)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.b_waddr   (r_idx),
				.b_wdata   (elem_v),
				.a_in      (ch_a[j]),
				.t_in      (ch_t[j]),
				.vld_in    (ch_vld[j]),
				.first_in  (ch_first[j]),
				.last_in   (ch_last[j]),
				.a_out     (ch_a[j+1]),
				.t_out     (ch_t[j+1]),
				.vld_out   (ch_vld[j+1]),
				.first_out (ch_first[j+1]),
				.last_out  (ch_last[j+1]),
				.res_in    (ch_res[j+1]),
				.res_out   (ch_res[j])
			);
		end
	endgenerate

	assign result_valid     = (state_q == ST_DRAIN);
	assign result.out_row   = FW'(i_q);
	assign result.out_col   = FW'(j_q);
	assign result.out_value = ch_res[0];
	assign result.last      = i_last && j_last;

endmodule

// ----- hw/rtl/mm_checker.sv -----
// -----------------------------------------------------------------------------
// Matrix multiply checker
// Port-level properties of the item and result channels.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input mm_pkg::in_item_t  item,
	input logic              result_valid,
	input logic              result_stall,
	input mm_pkg::out_item_t result
);

	`ASSERT_PROP(a_result_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(result), "result changed while stalled")
	`ASSERT_NEVER(a_idle_no_result, clk, arst_n, !item_stall && result_valid, "result offered while taking items")
	`ASSERT_PROP(a_compute_busy, clk, arst_n, item_valid && !item_stall && item.cmd == mm_pkg::CMD_COMPUTE |=> item_stall, "compute transfer did not stall input")
	`ASSERT_PROP(a_load_no_stall, clk, arst_n, item_valid && !item_stall && item.cmd != mm_pkg::CMD_COMPUTE |=> !item_stall, "load transfer stalled input")
	`ASSERT_PROP(a_last_ends, clk, arst_n, result_valid && !result_stall && result.last |=> !item_stall && !result_valid, "product did not end after last transfer")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
